/* rtl/scbp_pkg.sv */
`timescale 1ns / 1ps
// Package for the size-class buffer pool: status codes, register indexes
// and the fragment size clamp. No dependencies.
package scbp_pkg;

  // Result status codes.
  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_LIMIT      = 3'd1;
  localparam logic [2:0] ST_NO_HANDLES = 3'd2;
  localparam logic [2:0] ST_TOO_LARGE  = 3'd3;
  localparam logic [2:0] ST_BAD_HANDLE = 3'd4;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAGMENT_SIZE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_BUFFERS   = 4'd1;

  // Field widths fixed by the interface.
  localparam int FRAG_W = 17;
  localparam int MAXB_W = 9;

  localparam logic [FRAG_W-1:0] FRAG_RESET = 17'd1024;
  localparam logic [FRAG_W-1:0] FRAG_MAX   = 17'd65536;
  localparam logic [MAXB_W-1:0] MAXB_RESET = 9'd256;

  // A fragment size of zero acts as one; values above the maximum saturate.
  function automatic logic [FRAG_W-1:0] frag_clamp(input logic [FRAG_W-1:0] v);
    logic [FRAG_W-1:0] r;
    r = v;
    if (v == '0) begin
      r = FRAG_W'(1);
    end else if (v > FRAG_MAX) begin
      r = FRAG_MAX;
    end
    return r;
  endfunction

endpackage

/* rtl/scbp_ram.sv */
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module scbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* rtl/size_class_buffer_pool.sv */
`timescale 1ns / 1ps
// Size-class buffer pool top level: request sequencer, free lists and counters.
// Depends on scbp_pkg and scbp_ram.
//
// Usage: a request transfer on the input channel (in_valid / in_stall) carries
// action (0 get, 1 release), req_size and buf_handle. Each request yields
// exactly one result transfer on the output channel (out_valid / out_stall)
// with status, out_handle, size_class, capacity and reused.
// The block works on one request at a time and holds in_stall high while busy.
// A get finds its class with one shared shift-and-compare step per cycle; when
// a free-list handle is reused, the head is followed through the next-link
// memory. A release reads the handle info, then updates the list; a get that
// hits the limit goes straight to the result. The next request is taken the
// cycle after the result is registered. The result register holds while
// out_stall is high; a new result waits in the sequencer until the previous
// one is taken.
// Reset empties all free lists, forgets every handle and restores the
// registers (fragment_size 1024, max_buffers 256); no clearing pass is needed.
// The configuration port (cfg_valid / cfg_ready) is always ready.
module size_class_buffer_pool #(
  parameter int NUM_CLASSES = 8,
  parameter int MAX_HANDLES = 256
) (
  input  logic                           clk,
  input  logic                           rst,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [scbp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [scbp_pkg::FRAG_W-1:0]    cfg_data,
  // Request channel.
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic                           action,
  input  logic [31:0]                    req_size,
  input  logic [7:0]                     buf_handle,
  // Result channel.
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [2:0]                     status,
  output logic [7:0]                     out_handle,
  output logic [2:0]                     size_class,
  output logic [24:0]                    capacity,
  output logic                           reused
);

  import scbp_pkg::*;

  // Derived widths.
  localparam int HW   = $clog2(MAX_HANDLES);
  localparam int CW   = $clog2(MAX_HANDLES + 1);
  localparam int CLW  = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
  localparam int CAPW = 18 + NUM_CLASSES - 1;
  localparam int CMPW = (CW > MAXB_W) ? CW : MAXB_W;
  localparam int BW   = (CW > 8) ? CW : 8;
  localparam int RQW  = (CAPW > 32) ? CAPW : 32;
  localparam int CAPX = (CAPW > 25) ? CAPW : 25;
  localparam int CLX  = (CLW > 3) ? CLW : 3;
  localparam int INFW = CLW + 1;

  localparam logic [CLW-1:0] LAST_CLASS = CLW'(NUM_CLASSES - 1);
  localparam logic [CW-1:0]  HANDLE_CAP = CW'(MAX_HANDLES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SIZE = 3'd1;
  localparam logic [2:0] S_SRCH = 3'd2;
  localparam logic [2:0] S_POP1 = 3'd3;
  localparam logic [2:0] S_POP2 = 3'd4;
  localparam logic [2:0] S_REL1 = 3'd5;
  localparam logic [2:0] S_REL2 = 3'd6;
  localparam logic [2:0] S_EMIT = 3'd7;

  logic [2:0]        state;
  logic [FRAG_W-1:0] fragment_size;
  logic [MAXB_W-1:0] max_buffers;

  logic [CW-1:0]          outstanding_count;
  logic [CW-1:0]          minted_count;
  logic [CLW-1:0]         largest_class;
  logic [NUM_CLASSES-1:0] list_nonempty;
  logic [HW-1:0]          list_head [NUM_CLASSES];
  logic [HW-1:0]          list_tail [NUM_CLASSES];

  // Request registers and working registers.
  logic [31:0]    req_q;
  logic [HW-1:0]  bh_q;
  logic [BW-1:0]  bh_wide;
  logic [CLW-1:0] cls;
  logic [CAPW-1:0] cap;

  // Pending result.
  logic [2:0]      res_status;
  logic [HW-1:0]   res_handle;
  logic [CLW-1:0]  res_class;
  logic [CAPW-1:0] res_cap;
  logic            res_reused;
  logic            res_ok_get;

  // Memory ports.
  logic            info_we;
  logic [HW-1:0]   info_waddr;
  logic [INFW-1:0] info_wdata;
  logic [HW-1:0]   info_raddr;
  logic [INFW-1:0] info_rdata;
  logic            link_we;
  logic [HW-1:0]   link_rdata;

  logic            in_xfer;
  logic            load_out;
  logic [FRAG_W-1:0] fs_eff;
  logic [CAPW-1:0] cap_base;
  logic [CAPW-1:0] cap_of_cls;
  logic            hit;
  logic [CLW-1:0]  hit_cls;
  logic [BW-1:0]   in_bh_wide;
  logic [CMPW-1:0] out_cmp;
  logic [CMPW-1:0] max_cmp;
  logic [HW-1:0]   pop_handle;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign load_out  = (state == S_EMIT) && (!out_valid || !out_stall);

  // Effective class 0 capacity and the capacity of the selected class.
  assign fs_eff     = frag_clamp(fragment_size);
  assign cap_base   = CAPW'({fs_eff, 1'b0});
  assign cap_of_cls = cap_base << cls;

  assign in_bh_wide = BW'(buf_handle);
  assign out_cmp    = CMPW'(outstanding_count);
  assign max_cmp    = CMPW'(max_buffers);
  assign pop_handle = list_head[cls];

  // Handle info holds a free flag over the handle's class.
  assign info_raddr = (state == S_IDLE) ? in_bh_wide[HW-1:0] : bh_q;

  // First non-empty list from the request's class up to the largest class.
  always_comb begin
    hit     = 1'b0;
    hit_cls = '0;
    for (int i = NUM_CLASSES - 1; i >= 0; i--) begin
      if (list_nonempty[i] && (CLW'(i) >= cls) && (CLW'(i) <= largest_class)) begin
        hit     = 1'b1;
        hit_cls = CLW'(i);
      end
    end
  end

  // Memory write controls.
  always_comb begin
    info_we    = 1'b0;
    info_waddr = bh_q;
    info_wdata = {1'b0, cls};
    link_we    = 1'b0;
    unique case (state)
      S_REL2: begin
        info_we    = 1'b1;
        info_waddr = bh_q;
        info_wdata = {1'b1, cls};
        link_we    = list_nonempty[cls];
      end
      S_SRCH: begin
        info_we    = !hit && (minted_count != HANDLE_CAP);
        info_waddr = minted_count[HW-1:0];
        info_wdata = {1'b0, cls};
      end
      S_POP2: begin
        info_we    = 1'b1;
        info_waddr = pop_handle;
        info_wdata = {1'b0, cls};
      end
      default: begin
        info_we = 1'b0;
      end
    endcase
  end

  scbp_ram #(.WIDTH(INFW), .DEPTH(MAX_HANDLES)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (info_waddr),
    .wdata (info_wdata),
    .raddr (info_raddr),
    .rdata (info_rdata)
  );

  scbp_ram #(.WIDTH(HW), .DEPTH(MAX_HANDLES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (list_tail[cls]),
    .wdata (bh_q),
    .raddr (pop_handle),
    .rdata (link_rdata)
  );

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fragment_size <= FRAG_RESET;
      max_buffers   <= MAXB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == CFG_FRAGMENT_SIZE) begin
        fragment_size <= cfg_data;
      end else if (cfg_index == CFG_MAX_BUFFERS) begin
        max_buffers <= cfg_data[MAXB_W-1:0];
      end
    end
  end

  // Free-list heads and tails; validity lives in list_nonempty.
  always_ff @(posedge clk) begin
    if (state == S_REL2) begin
      list_tail[cls] <= bh_q;
      if (!list_nonempty[cls]) begin
        list_head[cls] <= bh_q;
      end
    end else if (state == S_POP2) begin
      list_head[cls] <= link_rdata;
    end
  end

  // Request sequencer and bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      outstanding_count <= '0;
      minted_count      <= '0;
      largest_class     <= '0;
      list_nonempty     <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_xfer) begin
            req_q   <= req_size;
            bh_q    <= in_bh_wide[HW-1:0];
            bh_wide <= in_bh_wide;
            cls     <= '0;
            cap     <= cap_base;
            if (action) begin
              state <= S_REL1;
            end else if (out_cmp >= max_cmp) begin
              res_status <= ST_LIMIT;
              state      <= S_EMIT;
            end else begin
              state <= S_SIZE;
            end
          end
        end
        // One shift-and-compare step per cycle picks the class.
        S_SIZE: begin
          if (RQW'(req_q) > RQW'(cap)) begin
            if (cls == LAST_CLASS) begin
              res_status <= ST_TOO_LARGE;
              state      <= S_EMIT;
            end else begin
              cap <= cap << 1;
              cls <= cls + CLW'(1);
            end
          end else begin
            state <= S_SRCH;
          end
        end
        S_SRCH: begin
          if (hit) begin
            cls   <= hit_cls;
            state <= S_POP1;
          end else if (minted_count == HANDLE_CAP) begin
            res_status <= ST_NO_HANDLES;
            state      <= S_EMIT;
          end else begin
            minted_count      <= minted_count + CW'(1);
            outstanding_count <= outstanding_count + CW'(1);
            if (cls > largest_class) begin
              largest_class <= cls;
            end
            res_status <= ST_OK;
            res_handle <= minted_count[HW-1:0];
            res_class  <= cls;
            res_cap    <= cap;
            res_reused <= 1'b0;
            state      <= S_EMIT;
          end
        end
        // Next-link read of the head is in flight.
        S_POP1: begin
          state <= S_POP2;
        end
        S_POP2: begin
          if (pop_handle == list_tail[cls]) begin
            list_nonempty[cls] <= 1'b0;
          end
          outstanding_count <= outstanding_count + CW'(1);
          res_status <= ST_OK;
          res_handle <= pop_handle;
          res_class  <= cls;
          res_cap    <= cap_of_cls;
          res_reused <= 1'b1;
          state      <= S_EMIT;
        end
        // Handle info is ready: reject unknown or already free handles.
        S_REL1: begin
          if ((bh_wide >= BW'(minted_count)) || info_rdata[CLW]) begin
            res_status <= ST_BAD_HANDLE;
            state      <= S_EMIT;
          end else begin
            cls   <= info_rdata[CLW-1:0];
            state <= S_REL2;
          end
        end
        S_REL2: begin
          list_nonempty[cls] <= 1'b1;
          if (outstanding_count != '0) begin
            outstanding_count <= outstanding_count - CW'(1);
          end
          res_status <= ST_OK;
          state      <= S_EMIT;
        end
        S_EMIT: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register; fields other than status are zero unless a get succeeded.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    logic [BW-1:0]   h_ext;
    logic [CLX-1:0]  c_ext;
    logic [CAPX-1:0] cap_ext;
    h_ext   = BW'(res_handle);
    c_ext   = CLX'(res_class);
    cap_ext = CAPX'(res_cap);
    if (load_out) begin
      status <= res_status;
      if ((res_status == ST_OK) && (state == S_EMIT) && res_ok_get) begin
        out_handle <= h_ext[7:0];
        size_class <= c_ext[2:0];
        capacity   <= cap_ext[24:0];
        reused     <= res_reused;
      end else begin
        out_handle <= '0;
        size_class <= '0;
        capacity   <= '0;
        reused     <= 1'b0;
      end
    end
  end

  // Marks a pending result that came from a successful get.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_ok_get <= 1'b0;
    end else if (in_xfer) begin
      res_ok_get <= 1'b0;
    end else if ((state == S_POP2) || ((state == S_SRCH) && !hit &&
                 (minted_count != HANDLE_CAP))) begin
      res_ok_get <= 1'b1;
    end
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for size_class_buffer_pool: random get and release traffic
// under several pool settings, with results checked against an in-bench allocator model.
// Depends on scbp_pkg and the size_class_buffer_pool RTL.
module testbench;
  import scbp_pkg::*;

  localparam int NUM_CLASSES = 8;
  localparam int MAX_HANDLES = 256;
  localparam logic ACT_GET     = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;
  // An index that maps to no register; writes to it must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 4'hF;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 32;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  handle;
    logic [2:0]  cls;
    logic [24:0] cap;
    logic        reused;
  } reply_t;

  // Allocator model: free lists per class, handle bookkeeping and the replies
  // still owed by the block, oldest first.
  class buffer_pool_model;
    logic [FRAG_W-1:0] frag;
    logic [MAXB_W-1:0] max_bufs;
    int                held_cnt;
    int                minted;
    int                top_class;
    bit                list_live[NUM_CLASSES];
    logic [7:0]        list_first[NUM_CLASSES];
    logic [7:0]        list_last[NUM_CLASSES];
    logic [7:0]        link[MAX_HANDLES];
    int                class_of[MAX_HANDLES];
    bit                on_list[MAX_HANDLES];
    reply_t            expected_replies[$];
    int                errors;

    function new();
      frag = FRAG_RESET;
      max_bufs = MAXB_RESET;
      held_cnt = 0;
      minted = 0;
      top_class = 0;
      errors = 0;
      foreach (list_live[i]) list_live[i] = 1'b0;
      foreach (on_list[i]) on_list[i] = 1'b0;
    endfunction

    // Bytes in class k: twice the fragment size, doubled per class step.
    function longint unsigned class_bytes(int k);
      longint unsigned f;
      f = frag;
      if (f < 1) f = 1;
      if (f > 65536) f = 65536;
      return (f * 2) << k;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAG_W-1:0] data);
      case (idx)
        CFG_FRAGMENT_SIZE: frag = data;
        CFG_MAX_BUFFERS: max_bufs = data[MAXB_W-1:0];
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_replies.size();
    endfunction

    // A handle that is handed out right now, or -1 when there is none.
    function int pick_held();
      int pool[$];
      for (int i = 0; i < minted; i++) begin
        if (!on_list[i]) pool.push_back(i);
      end
      if (pool.size() == 0) return -1;
      return pool[$urandom_range(0, pool.size() - 1)];
    endfunction

    // Apply one accepted request to the pool and queue the reply it must produce.
    function void take_request(logic act, logic [31:0] size, logic [7:0] h);
      reply_t          r;
      longint unsigned cap;
      int              k;
      int              c;
      bit              found;
      r = '0;
      r.status = ST_OK;
      found = 1'b0;
      if (act == ACT_RELEASE) begin
        if (h >= minted || on_list[h]) begin
          r.status = ST_BAD_HANDLE;
        end else begin
          // Append to the back of the handle's class list.
          c = class_of[h];
          if (list_live[c]) begin
            link[list_last[c]] = h;
          end else begin
            list_first[c] = h;
            list_live[c] = 1'b1;
          end
          list_last[c] = h;
          on_list[h] = 1'b1;
          if (held_cnt > 0) held_cnt--;
        end
      end else if (held_cnt >= max_bufs) begin
        r.status = ST_LIMIT;
      end else begin
        k = 0;
        cap = class_bytes(0);
        while (k < NUM_CLASSES && size > cap) begin
          cap = cap << 1;
          k++;
        end
        if (k >= NUM_CLASSES) begin
          r.status = ST_TOO_LARGE;
        end else begin
          // Reuse the front handle of the first non-empty list in the span.
          for (int i = k; i <= top_class && !found; i++) begin
            if (list_live[i]) begin
              found = 1'b1;
              r.handle = list_first[i];
              if (list_first[i] == list_last[i]) list_live[i] = 1'b0;
              else list_first[i] = link[list_first[i]];
              on_list[r.handle] = 1'b0;
              held_cnt++;
              r.cls = 3'(i);
              cap = class_bytes(i);
              r.cap = cap[24:0];
              r.reused = 1'b1;
            end
          end
          // Otherwise mint a fresh handle in the requested class.
          if (!found) begin
            if (minted >= MAX_HANDLES) begin
              r.status = ST_NO_HANDLES;
            end else begin
              r.handle = 8'(minted);
              class_of[minted] = k;
              on_list[minted] = 1'b0;
              minted++;
              if (k > top_class) top_class = k;
              held_cnt++;
              r.cls = 3'(k);
              r.cap = cap[24:0];
              r.reused = 1'b0;
            end
          end
        end
      end
      expected_replies.push_back(r);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void match_result(reply_t got);
      reply_t want;
      if (expected_replies.size() == 0) begin
        errors++;
        $display("%0t: result with no request outstanding, status %0d", $time, got.status);
        return;
      end
      want = expected_replies.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("out_handle", want.handle, got.handle);
      compare_field("size_class", want.cls, got.cls);
      compare_field("capacity", want.cap, got.cap);
      compare_field("reused", want.reused, got.reused);
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAG_W-1:0]    cfg_data;
  logic                 in_valid;
  logic                 in_stall;
  logic                 action;
  logic [31:0]          req_size;
  logic [7:0]           buf_handle;
  logic                 out_valid;
  logic                 out_stall;
  logic [2:0]           status;
  logic [7:0]           out_handle;
  logic [2:0]           size_class;
  logic [24:0]          capacity;
  logic                 reused;

  buffer_pool_model model;
  bit               quiet = 1'b0;
  int               idle_cycles = 0;

  size_class_buffer_pool u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .action     (action),
    .req_size   (req_size),
    .buf_handle (buf_handle),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .status     (status),
    .out_handle (out_handle),
    .size_class (size_class),
    .capacity   (capacity),
    .reused     (reused)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: stall for a random number of cycles, then take one transfer.
  initial begin
    int hold;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, 8);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid === 1'b1 && !rst));
      @(negedge clk);
    end
  end

  // Check every result transfer against the oldest owed reply.
  always @(posedge clk) begin
    reply_t seen;
    if (!rst && out_valid && !out_stall) begin
      seen = {status, out_handle, size_class, capacity, reused};
      model.match_result(seen);
    end
  end

  // End the run if no transfer of any kind happens for too long.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("size_class_buffer_pool test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Present one request after a random gap and wait for its transfer.
  task automatic send(input logic act, input logic [31:0] sz, input logic [7:0] h);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    req_size <= sz;
    buf_handle <= h;
    do @(posedge clk); while (in_stall);
    model.take_request(act, sz, h);
  endtask

  // Stop sending and wait until every owed reply has come back.
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (model.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [FRAG_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    model.set_reg(idx, data);
  endtask

  // Reprogram both registers once the pool is idle.
  task automatic new_phase(input logic [FRAG_W-1:0] frag_val,
                           input logic [FRAG_W-1:0] limit_val, input bit spare);
    settle();
    if (spare) cfg_write(CFG_UNMAPPED, 17'h1ABCD);
    cfg_write(CFG_FRAGMENT_SIZE, frag_val);
    cfg_write(CFG_MAX_BUFFERS, limit_val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // One random request: gets aim mostly inside a class, releases mostly
  // return a handle that is really out.
  task automatic random_item(input int get_pct);
    int              k;
    int              held;
    longint unsigned cap;
    longint unsigned lo;
    logic [31:0]     sz;
    logic [7:0]      h;
    logic            act;
    sz = $urandom;
    h = 8'($urandom_range(0, 255));
    act = ($urandom_range(0, 99) < get_pct) ? ACT_GET : ACT_RELEASE;
    k = $urandom_range(0, NUM_CLASSES - 1);
    cap = model.class_bytes(k);
    if (act == ACT_GET) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          lo = (k == 0) ? 0 : cap / 2 + 1;
          sz = $urandom_range(cap[31:0], lo[31:0]);
        end
        6: sz = cap[31:0] + $urandom_range(0, 1);
        7: ;
        8: begin
          cap = model.class_bytes(NUM_CLASSES - 1);
          sz = cap[31:0] + 1 + $urandom_range(0, 4095);
        end
        default: sz = $urandom_range(0, 1);
      endcase
    end else begin
      held = model.pick_held();
      if (held >= 0 && $urandom_range(0, 9) < 8) h = held[7:0];
    end
    send(act, sz, h);
  endtask

  task automatic run_mix(input int count, input int get_pct);
    repeat (count) begin
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      if ($urandom_range(0, 59) == 0) settle();
      random_item(get_pct);
    end
  endtask

  initial begin
    model = new();
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_valid = 1'b0;
    action = ACT_GET;
    req_size = '0;
    buf_handle = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: class edges, oversize requests, bad releases and reuse.
    send(ACT_GET, 32'd0, 8'd0);
    send(ACT_GET, 32'd2048, 8'd0);
    send(ACT_GET, 32'd2049, 8'd0);
    send(ACT_GET, 32'd262144, 8'd0);
    send(ACT_GET, 32'd262145, 8'd0);
    send(ACT_GET, 32'hFFFF_FFFF, 8'd0);
    send(ACT_RELEASE, 32'd0, 8'd0);
    send(ACT_RELEASE, 32'd0, 8'd0);
    send(ACT_RELEASE, 32'd0, 8'd255);
    send(ACT_GET, 32'd1, 8'd0);
    send(ACT_RELEASE, 32'd0, 8'd1);
    send(ACT_RELEASE, 32'd0, 8'd2);
    send(ACT_GET, 32'd100, 8'd0);
    send(ACT_GET, 32'd100, 8'd0);

    // A tight limit: gets are refused until releases bring the count down.
    new_phase(FRAG_RESET, 17'd3, 1'b1);
    send(ACT_GET, 32'd5, 8'd0);
    send(ACT_RELEASE, 32'd0, 8'd3);
    send(ACT_GET, 32'd5, 8'd0);
    send(ACT_RELEASE, 32'd0, 8'd2);
    send(ACT_GET, 32'd5, 8'd0);

    // Fragment size zero acts as one; a reused handle reports today's capacity.
    new_phase(17'd0, 17'd256, 1'b0);
    send(ACT_GET, 32'd2, 8'd0);
    send(ACT_GET, 32'd3, 8'd0);
    send(ACT_GET, 32'd256, 8'd0);
    send(ACT_GET, 32'd257, 8'd0);

    // Saturated fragment size and a limit of zero.
    new_phase(17'h1FFFF, 17'd0, 1'b0);
    send(ACT_GET, 32'd16777216, 8'd0);
    send(ACT_RELEASE, 32'd0, 8'd0);

    // Random traffic under a series of settings.
    new_phase(FRAG_RESET, 17'd256, 1'b0);
    run_mix(120, 60);
    new_phase(17'($urandom_range(1, 64)), 17'($urandom_range(1, 16)), 1'b0);
    run_mix(120, 60);
    new_phase(17'h1FFFF, 17'd256, 1'b0);
    run_mix(100, 60);

    // Mostly gets until the whole handle space is minted; upper limit bits drop.
    new_phase(17'd65536, 17'h1FF00, 1'b0);
    for (int n = 0; n < 500 && model.minted < MAX_HANDLES; n++) begin
      if ($urandom_range(0, 29) == 0) quiet = !quiet;
      random_item(90);
    end
    run_mix(50, 90);

    // Largest limit with every handle minted: new handles are refused.
    new_phase(17'($urandom), 17'd511, 1'b0);
    run_mix(200, 55);

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (model.errors == 0) begin
      $display("size_class_buffer_pool test passed");
    end else begin
      $display("size_class_buffer_pool test failed");
    end
    $finish;
  end

endmodule

/* size_class_buffer_pool.f */
rtl/scbp_pkg.sv
rtl/scbp_ram.sv
rtl/size_class_buffer_pool.sv
tb/testbench.sv
